/* hw/rtl/mrtu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU frame engine package
// Shared types and protocol constants of the frame engine.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'ha001;

  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
  localparam logic [7:0] FC_EXC_FLAG    = 8'h80;

  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_WRH   = 8'b0000_0100,
    S_WRL   = 8'b0000_1000,
    S_WRW   = 8'b0001_0000,
    S_START = 8'b0010_0000,
    S_SEND  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    RSP_EXC  = 2'd0,
    RSP_READ = 2'd1,
    RSP_ECHO = 2'd2
  } rsp_e;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctl_t;

endpackage

/* hw/rtl/mrtu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrtu_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/mrtu_crc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial CRC-16/MODBUS unit
// Folds one byte into the running CRC, one bit per cycle.
// ----------------------------------------------------------------------------
module mrtu_crc import mrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctl_t    ctl_i,
  output logic        busy_o,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [2:0]  bit_q, bit_d;
  logic        busy_q, busy_d;

  always_comb begin
    crc_d  = crc_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    if (ctl_i.init) begin
      crc_d  = CRC_INIT;
      busy_d = 1'b0;
    end else if (ctl_i.start) begin
      crc_d  = crc_q ^ {8'h00, ctl_i.data};
      bit_d  = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = (crc_q >> 1) ^ (crc_q[0] ? CRC_POLY : 16'h0000);
      bit_d = bit_q + 3'd1;
      if (bit_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      bit_q  <= 3'd0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      bit_q  <= bit_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

/* hw/rtl/modbus_rtu_server_frame_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU server frame engine
// Collects a frame, checks it on the receive timeout and answers function
// codes 03, 06 and 16 from a register file, with a freshly computed CRC.
// ----------------------------------------------------------------------------
// A received byte from the third on starts the bit-serial CRC unit on the byte two
// before it; input stalls while the unit is busy. A dropped frame's timeout passes
// S_CHECK and S_DONE; an answered one passes S_CHECK, S_WRH, S_WRL, S_WRW per word
// written by code 16, S_START, S_SEND for data and CRC bytes, and S_DONE. Each byte
// waits for the CRC unit and for output stalls. Reset clears the register file, the
// frame count and sets the station address to 1; the frame store is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_server_frame_engine_top import mrtu_pkg::*; #(
  parameter int NUM_REGS    = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  state_e      state_q, state_d;
  rsp_e        rsp_q, rsp_d;
  logic [7:0]  addr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [7:0]  hdr_q [6];
  logic [7:0]  b1_q, b2_q;
  logic [15:0] rf_q [NUM_REGS];
  logic [RW-1:0] widx_q, widx_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  hi_q;
  logic [7:0]  code_q, code_d;
  logic [6:0]  k_q, k_d, n_q, n_d;
  logic        selhi_q, selhi_d;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q, olast_d;

  logic        in_acc, out_free, byte_acc;
  logic        rf_we;
  logic [RW-1:0] rf_widx;
  logic [15:0] rf_wdata, rf_rd;
  logic [7:0]  ram_rdata, dbyte;
  logic [7:0]  fc, start, count;
  logic [8:0]  span;
  logic        crc_busy;
  logic [15:0] crc;
  crc_ctl_t    crc_ctl;

  assign in_stall_o  = (state_q != S_IDLE) || crc_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign byte_acc    = in_acc && !func_i && (cnt_q < CW'(FRAME_BYTES));
  assign out_free    = !ovalid_q || !out_stall_i;
  assign out_valid_o = ovalid_q;
  assign tx_byte_o   = obyte_q;
  assign tx_last_o   = olast_q;

  assign fc    = hdr_q[1];
  assign start = hdr_q[3];
  assign count = hdr_q[5];
  assign span  = {1'b0, start} + {1'b0, count};
  assign rf_rd = (32'(widx_q) < NUM_REGS) ? rf_q[widx_q] : 16'h0000;

  mrtu_ram #(.Width(8), .Depth(FRAME_BYTES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (byte_acc),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  mrtu_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .busy_o (crc_busy),
    .crc_o  (crc)
  );

  // Response data byte at position k, before the CRC.
  always_comb begin
    dbyte = 8'h00;
    case (rsp_q)
      RSP_EXC: begin
        case (k_q)
          7'd0:    dbyte = addr_q;
          7'd1:    dbyte = fc ^ FC_EXC_FLAG;
          default: dbyte = code_q;
        endcase
      end
      RSP_READ: begin
        case (k_q)
          7'd0:    dbyte = hdr_q[0];
          7'd1:    dbyte = fc;
          7'd2:    dbyte = {count[6:0], 1'b0};
          default: dbyte = selhi_q ? rf_rd[15:8] : rf_rd[7:0];
        endcase
      end
      default: begin
        case (k_q[2:0])
          3'd0:    dbyte = hdr_q[0];
          3'd1:    dbyte = hdr_q[1];
          3'd2:    dbyte = hdr_q[2];
          3'd3:    dbyte = hdr_q[3];
          3'd4:    dbyte = hdr_q[4];
          default: dbyte = hdr_q[5];
        endcase
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    rsp_d    = rsp_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    widx_d   = widx_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    code_d   = code_q;
    k_d      = k_q;
    n_d      = n_q;
    selhi_d  = selhi_q;
    ovalid_d = ovalid_q && out_stall_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    rf_we    = 1'b0;
    rf_widx  = widx_q;
    rf_wdata = {hi_q, ram_rdata};
    crc_ctl  = '{init: 1'b0, start: 1'b0, data: b2_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (func_i) begin
            state_d = S_CHECK;
          end else if (cnt_q < CW'(FRAME_BYTES)) begin
            cnt_d = cnt_q + CW'(1);
            // The CRC covers everything but the two most recent bytes.
            crc_ctl.start = (cnt_q >= CW'(2));
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      S_CHECK: begin
        state_d = S_DONE;
        if (!ovf_q && (cnt_q >= CW'(4)) && (hdr_q[0] == addr_q) && (crc == {b1_q, b2_q}))
        begin
          if ((fc != FC_READ_HOLD) && (fc != FC_WRITE_ONE) && (fc != FC_WRITE_MULTI)) begin
            rsp_d   = RSP_EXC;
            code_d  = EXC_ILLEGAL_FUNC;
            state_d = S_START;
          end else if (cnt_q >= CW'(8)) begin
            if (fc == FC_READ_HOLD) begin
              state_d = S_START;
              if (span > 9'(NUM_REGS)) begin
                rsp_d  = RSP_EXC;
                code_d = EXC_ILLEGAL_ADDR;
              end else begin
                rsp_d = RSP_READ;
              end
            end else if (fc == FC_WRITE_ONE) begin
              state_d = S_START;
              if ({1'b0, start} >= 9'(NUM_REGS)) begin
                rsp_d  = RSP_EXC;
                code_d = EXC_ILLEGAL_ADDR;
              end else begin
                rsp_d    = RSP_ECHO;
                rf_we    = 1'b1;
                rf_widx  = start[RW-1:0];
                rf_wdata = {hdr_q[4], hdr_q[5]};
              end
            end else if (10'(cnt_q) >= ({1'b0, count, 1'b0} + 10'd9)) begin
              state_d = S_START;
              if (span > 9'(NUM_REGS)) begin
                rsp_d  = RSP_EXC;
                code_d = EXC_ILLEGAL_ADDR;
              end else begin
                rsp_d = RSP_ECHO;
                if (count != 8'h00) begin
                  state_d = S_WRH;
                  widx_d  = start[RW-1:0];
                  ptr_d   = AW'(7);
                  rem_d   = count;
                end
              end
            end
          end
        end
      end
      S_WRH: begin
        ptr_d   = ptr_q + AW'(1);
        state_d = S_WRL;
      end
      S_WRL: begin
        ptr_d   = ptr_q + AW'(1);
        state_d = S_WRW;
      end
      S_WRW: begin
        rf_we  = 1'b1;
        widx_d = widx_q + RW'(1);
        rem_d  = rem_q - 8'd1;
        state_d = (rem_q == 8'd1) ? S_START : S_WRH;
      end
      S_START: begin
        crc_ctl.init = 1'b1;
        k_d     = 7'd0;
        selhi_d = 1'b1;
        widx_d  = start[RW-1:0];
        case (rsp_q)
          RSP_EXC:  n_d = 7'd3;
          RSP_READ: n_d = 7'd3 + {count[5:0], 1'b0};
          default:  n_d = 7'd6;
        endcase
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free && !crc_busy) begin
          ovalid_d = 1'b1;
          k_d      = k_q + 7'd1;
          if (k_q < n_q) begin
            obyte_d       = dbyte;
            olast_d       = 1'b0;
            crc_ctl.start = 1'b1;
            crc_ctl.data  = dbyte;
            if (k_q >= 7'd3) begin
              selhi_d = !selhi_q;
              if (!selhi_q) begin
                widx_d = widx_q + RW'(1);
              end
            end
          end else if (k_q == n_q) begin
            obyte_d = crc[7:0];
            olast_d = 1'b0;
          end else begin
            obyte_d = crc[15:8];
            olast_d = 1'b1;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        crc_ctl.init = 1'b1;
        cnt_d   = '0;
        ovf_d   = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      addr_q   <= 8'h01;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i] <= 16'h0000;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      if (rf_we) begin
        rf_q[rf_widx] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    widx_q  <= widx_d;
    ptr_q   <= ptr_d;
    rem_q   <= rem_d;
    code_q  <= code_d;
    k_q     <= k_d;
    n_q     <= n_d;
    selhi_q <= selhi_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    if (state_q == S_WRL) begin
      hi_q <= ram_rdata;
    end
    if (byte_acc) begin
      b2_q <= b1_q;
      b1_q <= rx_byte_i;
      if (cnt_q < CW'(6)) begin
        hdr_q[cnt_q[2:0]] <= rx_byte_i;
      end
    end
  end

endmodule

/* sim/modbus_rtu_server_frame_engine_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU server frame engine testbench
// Streams Modbus RTU request frames, noise and broken frames into the engine.
// A model of the server predicts every response byte, and each word the
// engine sends is compared against it.
// ----------------------------------------------------------------------------
module modbus_rtu_server_frame_engine_top_tb import mrtu_pkg::*; ();

  localparam int NREGS      = 16;
  localparam int FBYTES     = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 200;

  typedef struct packed {
    logic       tmo;
    logic [7:0] data;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       func_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic       tx_last_o;

  modbus_rtu_server_frame_engine_top #(
    .NUM_REGS   (NREGS),
    .FRAME_BYTES(FBYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .tx_byte_o  (tx_byte_o),
    .tx_last_o  (tx_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Server model state.
  logic [7:0]  frame_buf [FBYTES];
  int          frame_len;
  logic        frame_ovf;
  logic [15:0] hold_regs [NREGS];
  logic [7:0]  station;

  rx_word_t pending_words [$];
  tx_word_t reply_q [$];
  int       errors;
  int       idle_cycles;
  bit       bursty;
  int       hold_reqs;
  int       holds_done;
  logic     in_fire;
  logic     out_fire;

  function automatic logic [15:0] crc16(logic [7:0] d [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (d[i]) begin
      c = c ^ {8'h00, d[i]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  // Checks the collected frame and queues the response it should cause.
  function automatic void close_frame();
    logic [7:0]  body [$];
    logic [7:0]  rsp [$];
    logic [7:0]  fc;
    logic [15:0] c;
    int          st;
    int          cnt;
    if (!frame_ovf && frame_len >= 4 && frame_buf[0] == station) begin
      for (int i = 0; i < frame_len - 2; i++) body.push_back(frame_buf[i]);
      if (crc16(body) == {frame_buf[frame_len-1], frame_buf[frame_len-2]}) begin
        fc = frame_buf[1];
        st = frame_buf[3];
        cnt = frame_buf[5];
        if (fc != FC_READ_HOLD && fc != FC_WRITE_ONE && fc != FC_WRITE_MULTI) begin
          rsp = '{station, fc + FC_EXC_FLAG, EXC_ILLEGAL_FUNC};
        end else if (frame_len < 8) begin
          // Too short for its function: dropped.
        end else if (fc == FC_READ_HOLD) begin
          if (st + cnt > NREGS) begin
            rsp = '{station, fc + FC_EXC_FLAG, EXC_ILLEGAL_ADDR};
          end else begin
            rsp = '{frame_buf[0], fc, 8'((cnt * 2) & 8'hff)};
            for (int i = 0; i < cnt; i++) begin
              rsp.push_back(hold_regs[st+i][15:8]);
              rsp.push_back(hold_regs[st+i][7:0]);
            end
          end
        end else if (fc == FC_WRITE_ONE) begin
          if (st >= NREGS) begin
            rsp = '{station, fc + FC_EXC_FLAG, EXC_ILLEGAL_ADDR};
          end else begin
            hold_regs[st] = {frame_buf[4], frame_buf[5]};
            for (int i = 0; i < 6; i++) rsp.push_back(frame_buf[i]);
          end
        end else if (frame_len >= 9 + 2 * cnt) begin
          if (st + cnt > NREGS) begin
            rsp = '{station, fc + FC_EXC_FLAG, EXC_ILLEGAL_ADDR};
          end else begin
            for (int i = 0; i < cnt; i++)
              hold_regs[st+i] = {frame_buf[7+2*i], frame_buf[8+2*i]};
            for (int i = 0; i < 6; i++) rsp.push_back(frame_buf[i]);
          end
        end
      end
    end
    if (rsp.size() != 0) begin
      c = crc16(rsp);
      rsp.push_back(c[7:0]);
      rsp.push_back(c[15:8]);
      foreach (rsp[i]) reply_q.push_back('{rsp[i], i == rsp.size() - 1});
    end
    frame_len = 0;
    frame_ovf = 1'b0;
  endfunction

  function automatic void take_word(rx_word_t w);
    if (w.tmo) begin
      close_frame();
    end else if (frame_len < FBYTES) begin
      frame_buf[frame_len] = w.data;
      frame_len++;
    end else begin
      frame_ovf = 1'b1;
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Acceptance, prediction and checking at the rising edge.
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    out_fire <= out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) take_word('{func_i, rx_byte_i});
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report("unexpected word", tx_byte_o, 0);
        end else begin
          if (tx_byte_o !== reply_q[0].data) report("tx_byte", tx_byte_o, reply_q[0].data);
          if (tx_last_o !== reply_q[0].last) report("tx_last", tx_last_o, reply_q[0].last);
          void'(reply_q.pop_front());
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sender: feeds words from the pending queue, with random gaps when bursty.
  int in_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else if (in_valid_i && !in_fire) begin
      // Stalled word stays put.
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap--;
    end else if (pending_words.size() != 0) begin
      {func_i, rx_byte_i} <= pending_words.pop_front();
      in_valid_i <= 1'b1;
      in_gap = bursty ? $urandom_range(0, 6) : 0;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random stall per word when bursty, plus long hold-offs on request.
  int out_wait;
  int long_cnt;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait = 0;
      long_cnt = 0;
      holds_done = 0;
    end else if (long_cnt > 0) begin
      out_stall_i <= 1'b1;
      long_cnt--;
    end else if (holds_done < hold_reqs) begin
      holds_done++;
      long_cnt = LONG_HOLD;
      out_stall_i <= 1'b1;
    end else begin
      if (out_fire) out_wait = bursty ? $urandom_range(0, 6) : 0;
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus helpers.
  int words_sent;

  task automatic push_byte(logic [7:0] b);
    pending_words.push_back('{1'b0, b});
    words_sent++;
  endtask

  task automatic push_timeout();
    pending_words.push_back('{1'b1, 8'($urandom)});
    words_sent++;
  endtask

  task automatic send_frame(logic [7:0] body [$], bit good_crc = 1);
    logic [15:0] c;
    c = crc16(body);
    if (!good_crc) c = c ^ 16'(1 << $urandom_range(0, 15));
    foreach (body[i]) push_byte(body[i]);
    push_byte(c[7:0]);
    push_byte(c[15:8]);
    push_timeout();
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  task automatic send_read(logic [7:0] adr, int st, int cnt);
    send_frame('{adr, FC_READ_HOLD, rnd8(), 8'(st), rnd8(), 8'(cnt)});
  endtask

  task automatic send_write_one(logic [7:0] adr, int st, logic [15:0] v);
    send_frame('{adr, FC_WRITE_ONE, rnd8(), 8'(st), v[15:8], v[7:0]});
  endtask

  task automatic send_write_multi(logic [7:0] adr, int st, int cnt, int nwords);
    logic [7:0] body [$];
    body = '{adr, FC_WRITE_MULTI, rnd8(), 8'(st), rnd8(), 8'(cnt), rnd8()};
    for (int i = 0; i < 2 * nwords; i++) body.push_back(rnd8());
    send_frame(body);
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || reply_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_station(logic [7:0] a);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    station = a;
  endtask

  task automatic random_frame();
    int kind;
    int st;
    int cnt;
    kind = $urandom_range(0, 99);
    st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, NREGS - 1);
    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                      : $urandom_range(0, NREGS - st > 6 ? 6 : NREGS - st);
    if (kind < 30) send_read(station, st, cnt);
    else if (kind < 50) send_write_one(station, st, 16'($urandom));
    else if (kind < 70) send_write_multi(station, st, cnt > 6 ? 6 : cnt,
                                         $urandom_range(0, 9) == 0 ? 0 : (cnt > 6 ? 6 : cnt));
    else if (kind < 76) send_frame('{station, rnd8()});
    else if (kind < 82) send_read(station + 8'd1, st, cnt);
    else if (kind < 88) send_frame('{station, FC_READ_HOLD, rnd8(), 8'(st), rnd8(), 8'(cnt)}, 0);
    else if (kind < 94) send_frame('{station, FC_WRITE_ONE, rnd8()});
    else begin
      repeat ($urandom_range(0, 5)) push_byte(rnd8());
      push_timeout();
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    bursty = 1;
    hold_reqs = 0;
    words_sent = 0;
    frame_len = 0;
    frame_ovf = 1'b0;
    station = 8'd1;
    in_fire = 1'b0;
    out_fire = 1'b0;
    foreach (hold_regs[i]) hold_regs[i] = 16'h0000;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset address.
    send_read(station, 0, 2);
    send_write_one(station, NREGS - 1, 16'hffff);
    send_write_multi(station, 0, 2, 2);
    send_read(station, NREGS - 2, 2);
    send_frame('{station, 8'hff});
    send_read(station, NREGS - 1, 2);
    send_write_one(station, NREGS, 16'h1234);
    send_write_multi(station, 15, 2, 2);
    send_write_multi(station, 0, 3, 2);
    send_read(station, 0, 0);
    send_write_multi(station, 4, 0, 0);
    send_frame('{station, FC_READ_HOLD, 8'h00, 8'h00}, 1);
    push_byte(station); push_byte(FC_READ_HOLD); push_timeout();
    push_timeout();
    repeat (FBYTES + 3) push_byte(rnd8());
    push_timeout();
    send_read(station, 0, 0);
    wait_idle();

    // Random phases over several station addresses, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_station(8'h00);
        1: set_station(8'hff);
        2: set_station(rnd8());
        default: set_station(8'd1 + 8'($urandom_range(0, 200)));
      endcase
      bursty = (ph != 3);
      if (ph == 2) begin
        // Receiver holds off while the sender keeps offering frames.
        hold_reqs++;
        repeat (2) send_read(station, 0, NREGS);
      end
      random_frame();
      wait_idle();
    end

    set_station(rnd8());
    while (words_sent < 220) random_frame();
    wait_idle();

    if (errors == 0 && reply_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
